// ===== src/dfhte_pkg.sv =====
// Shared types, command codes and code tables for the fixed Huffman token encoder.
package dfhte_pkg;

  localparam int TOK_W   = 31;  // longest token: 8 + 5 + 5 + 13 bits
  localparam int NBITS_W = 5;
  localparam int ACC_W   = TOK_W + 7;
  localparam int OBUF_BYTES = 4;

  localparam logic [2:0] CMD_LITERAL = 3'd0;
  localparam logic [2:0] CMD_MATCH   = 3'd1;
  localparam logic [2:0] CMD_HEADER  = 3'd2;
  localparam logic [2:0] CMD_EOB     = 3'd3;
  localparam logic [2:0] CMD_FLUSH   = 3'd4;

  localparam logic [8:0] LIT_CODE_LO  = 9'h030;
  localparam logic [8:0] LIT_CODE_HI  = 9'h190;
  localparam logic [7:0] LIT_SPLIT    = 8'd144;
  localparam logic [7:0] LEN_CODE8    = 8'hC0;
  localparam int         LEN_SYM8_IDX = 23;

  localparam logic [8:0] LEN_MIN  = 9'd3;
  localparam logic [8:0] LEN_MAX  = 9'd258;
  localparam logic [15:0] DIST_MIN = 16'd1;
  localparam logic [15:0] DIST_MAX = 16'd32768;

  localparam logic [8:0] LEN_BASE [29] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };
  localparam logic [2:0] LEN_EXTRA [29] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0
  };
  localparam logic [15:0] DIST_BASE [30] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
    16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
    16'd8193, 16'd12289, 16'd16385, 16'd24577
  };
  localparam logic [3:0] DIST_EXTRA [30] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  literal;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
    logic        final_block;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  // Token bits in stream order, oldest bit at bit 0.
  typedef struct packed {
    logic [TOK_W-1:0]   bits;
    logic [NBITS_W-1:0] nbits;
    logic               flush;
  } tok_t;

endpackage

// ===== src/deflate_fixed_huffman_token_encoder.sv =====
// Top level of the fixed Huffman deflate token encoder: token register, bit packer, byte output.
//
//   channel   direction  handshake                     payload
//   token     in         token_valid / token_ready     dfhte_pkg::in_t
//   stream    out        stream_valid / stream_ready   dfhte_pkg::out_t
//
// A token is held in an input register, encoded and merged with the pending bits, and the
// finished bytes (0 to 4) go to a byte buffer that drains one byte a cycle while
// stream_ready is high. A token producing at most one byte then sustains one token per
// cycle; a token producing more bytes holds the next one until its bytes have left through
// the single byte port. Synchronous reset clears the pending bits, the token register and
// the buffer. A stall on stream_ready holds the buffer and backs up into token_ready.
module deflate_fixed_huffman_token_encoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            token_valid,
  output logic            token_ready,
  input  dfhte_pkg::in_t  token,
  output logic            stream_valid,
  input  logic            stream_ready,
  output dfhte_pkg::out_t stream_data
);
  import dfhte_pkg::*;

  in_t              inq;
  logic             inq_valid;
  tok_t             tok;
  logic [6:0]       pending_bits;
  logic [2:0]       pending_count;
  logic [8*OBUF_BYTES-1:0] obuf;
  logic [2:0]       ocnt;

  logic             advance;
  logic [ACC_W-1:0] acc;
  logic [5:0]       acc_n;
  logic [ACC_W-1:0] acc_rest;
  logic [2:0]       nbytes;

  dfhte_encode u_encode (
    .item (inq),
    .tok  (tok)
  );

  // Advance the held token once the buffer will be empty after this cycle.
  assign advance     = inq_valid && ((ocnt == 3'd0) || (ocnt == 3'd1 && stream_ready));
  assign token_ready = !inq_valid || advance;

  // Merge the token behind the pending bits; a flush pads any pending bits to a byte.
  always_comb begin
    acc = {{(ACC_W-7){1'b0}}, pending_bits} | ({7'b0, tok.bits} << pending_count);
    if (tok.flush) begin
      acc_n = (pending_count != 3'd0) ? 6'd8 : 6'd0;
    end else begin
      acc_n = {3'b000, pending_count} + {1'b0, tok.nbits};
    end
    nbytes   = acc_n[5:3];
    acc_rest = acc >> {nbytes, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (token_ready) begin
      inq_valid <= token_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (token_ready && token_valid) begin
      inq <= token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (advance) begin
      pending_bits  <= acc_rest[6:0];
      pending_count <= acc_n[2:0];
    end
  end

  // Byte buffer: load whole bytes on advance, drop the front byte on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else if (advance) begin
      ocnt <= nbytes;
    end else if (stream_valid && stream_ready) begin
      ocnt <= ocnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      obuf <= acc[8*OBUF_BYTES-1:0];
    end else if (stream_valid && stream_ready) begin
      obuf <= {8'b0, obuf[8*OBUF_BYTES-1:8]};
    end
  end

  assign stream_valid          = (ocnt != 3'd0);
  assign stream_data.out_byte  = obuf[7:0];
  assign stream_data.last_byte = (ocnt == 3'd1);

endmodule

// ===== src/dfhte_encode.sv =====
// Token to bit-string encoder: fixed Huffman codes and extra bits, in stream order.
module dfhte_encode (
  input  dfhte_pkg::in_t  item,
  output dfhte_pkg::tok_t tok
);
  import dfhte_pkg::*;

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int k = 0; k < 9; k++) r[k] = v[8-k];
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  function automatic logic [6:0] rev7(input logic [6:0] v);
    logic [6:0] r;
    for (int k = 0; k < 7; k++) r[k] = v[6-k];
    return r;
  endfunction

  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int k = 0; k < 5; k++) r[k] = v[4-k];
    return r;
  endfunction

  logic [8:0]  lit_code;
  logic [8:0]  len_c;
  logic [15:0] dist_c;
  logic [4:0]  len_idx;
  logic [4:0]  dist_idx;
  logic [7:0]  len_code_rev;
  logic [3:0]  len_code_n;
  logic [4:0]  len_extra_v;
  logic [12:0] dist_extra_v;
  logic [3:0]  off1;
  logic [4:0]  off2;
  logic [4:0]  off3;
  logic [TOK_W-1:0] match_bits;
  logic [NBITS_W-1:0] match_n;
  logic [8:0]  len_rem;
  logic [15:0] dist_rem;

  // Clamp, then find the table row by a row of parallel compares.
  always_comb begin
    len_c  = item.match_length;
    if (len_c < LEN_MIN) len_c = LEN_MIN;
    if (len_c > LEN_MAX) len_c = LEN_MAX;
    dist_c = item.match_distance;
    if (dist_c < DIST_MIN) dist_c = DIST_MIN;
    if (dist_c > DIST_MAX) dist_c = DIST_MAX;

    len_idx = '0;
    for (int k = 1; k < 29; k++) begin
      if (len_c >= LEN_BASE[k]) len_idx = 5'(k);
    end
    dist_idx = '0;
    for (int k = 1; k < 30; k++) begin
      if (dist_c >= DIST_BASE[k]) dist_idx = 5'(k);
    end
  end

  always_comb begin
    if (len_idx < 5'(LEN_SYM8_IDX)) begin
      len_code_rev = {1'b0, rev7({2'b00, len_idx + 5'd1})};
      len_code_n   = 4'd7;
    end else begin
      len_code_rev = rev8(LEN_CODE8 + {3'b000, len_idx - 5'(LEN_SYM8_IDX)});
      len_code_n   = 4'd8;
    end
    len_rem      = len_c - LEN_BASE[len_idx];
    dist_rem     = dist_c - DIST_BASE[dist_idx];
    len_extra_v  = len_rem[4:0];
    dist_extra_v = dist_rem[12:0];

    off1 = len_code_n;
    off2 = {1'b0, off1} + {2'b00, LEN_EXTRA[len_idx]};
    off3 = off2 + 5'd5;

    match_bits = {23'b0, len_code_rev}
               | ({26'b0, len_extra_v} << off1)
               | ({26'b0, rev5(dist_idx)} << off2)
               | ({18'b0, dist_extra_v} << off3);
    match_n    = off3 + {1'b0, DIST_EXTRA[dist_idx]};
  end

  always_comb begin
    lit_code  = (item.literal < LIT_SPLIT)
              ? (LIT_CODE_LO + {1'b0, item.literal})
              : (LIT_CODE_HI + {1'b0, item.literal - LIT_SPLIT});
    tok = '0;
    unique case (item.command)
      CMD_LITERAL: begin
        if (item.literal < LIT_SPLIT) begin
          tok.bits  = {23'b0, rev8(lit_code[7:0])};
          tok.nbits = 5'd8;
        end else begin
          tok.bits  = {22'b0, rev9(lit_code)};
          tok.nbits = 5'd9;
        end
      end
      CMD_MATCH: begin
        tok.bits  = match_bits;
        tok.nbits = match_n;
      end
      CMD_HEADER: begin
        // BFINAL, then BTYPE 01 low bit first
        tok.bits  = {28'b0, 1'b0, 1'b1, item.final_block};
        tok.nbits = 5'd3;
      end
      CMD_EOB: begin
        tok.nbits = 5'd7;
      end
      CMD_FLUSH: begin
        tok.flush = 1'b1;
      end
      default: begin
        tok = '0;
      end
    endcase
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the fixed Huffman deflate token encoder.
`timescale 1ns / 1ps

module testbench;
  import dfhte_pkg::*;

  // Unused command codes above flush; the block must swallow them silently.
  localparam logic [2:0] CMD_UNUSED_LO = CMD_FLUSH + 3'd1;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // Fixed Huffman code points, kept separate from the package tables.
  localparam int LIT_BREAK      = 144;
  localparam int LIT_CODE_A     = 'h30;
  localparam int LIT_CODE_B     = 'h190;
  localparam int LEN_SYM_FIRST  = 257;
  localparam int LEN_SYM_SHORT  = 280;   // symbols below this use 7-bit codes
  localparam int LEN_CODE_EIGHT = 'hC0;
  localparam int LEN_LONGEST    = 258;
  localparam int LEN_SHORTEST   = 3;
  localparam int DIST_LONGEST   = 32768;
  localparam int HDR_FINAL      = 'b110; // BFINAL=1 then BTYPE 01, as sent MSB first
  localparam int HDR_MORE       = 'b010;
  localparam int EOB_CODE       = 0;

  localparam int IDLE_LIMIT  = 2000;     // cycles with no transfer on either channel
  localparam int DRAIN_TAIL  = 16;

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  token_valid  = 1'b0;
  in_t   token        = '0;
  logic  stream_ready = 1'b0;
  logic  token_ready;
  logic  stream_valid;
  out_t  stream_data;

  int tx_idle_pct = 30;
  int rx_idle_pct = 68;

  // Predictor state: bits still waiting to fill a byte, oldest at bit 0.
  logic [6:0] pend_bits = '0;
  int         pend_cnt  = 0;
  logic [63:0] acc;
  int          acc_n;

  out_t expected_bytes[$];

  int errors       = 0;
  int tokens_sent  = 0;
  int bytes_seen   = 0;
  int idle_cycles  = 0;
  int n_literal    = 0;
  int n_match      = 0;
  int n_header     = 0;
  int n_eob        = 0;
  int n_flush      = 0;
  int n_empty_fl   = 0;
  int n_ignored    = 0;
  int n_clamped    = 0;

  deflate_fixed_huffman_token_encoder u_top (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token        (token),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_data  (stream_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bit packer of the predictor
  // ---------------------------------------------------------------------------

  // Append a Huffman code, most significant bit first into the stream.
  function automatic void put_msb(input int code, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      acc[acc_n] = code[i];
      acc_n++;
    end
  endfunction

  // Append extra bits, least significant bit first.
  function automatic void put_lsb(input int value, input int nbits);
    for (int i = 0; i < nbits; i++) begin
      acc[acc_n] = value[i];
      acc_n++;
    end
  endfunction

  // Walk the length symbols; the span of each is 2**extra and the last one is 258 alone.
  function automatic void length_slot(input int len, output int idx, output int base,
                                      output int xbits);
    base  = LEN_SHORTEST;
    idx   = 0;
    xbits = 0;
    if (len == LEN_LONGEST) begin
      idx  = 28;
      base = LEN_LONGEST;
    end else begin
      xbits = 0;
      while (len >= base + (1 << xbits)) begin
        base += 1 << xbits;
        idx++;
        xbits = (idx < 8) ? 0 : idx / 4 - 1;
      end
    end
  endfunction

  // Same walk for distance codes: two codes per extra-bit count after the first four.
  function automatic void distance_slot(input int distance, output int idx, output int base,
                                        output int xbits);
    base  = 1;
    idx   = 0;
    xbits = 0;
    while (distance >= base + (1 << xbits)) begin
      base += 1 << xbits;
      idx++;
      xbits = (idx < 4) ? 0 : idx / 2 - 1;
    end
  endfunction

  // Work out the bytes that one accepted token completes and queue them.
  function automatic void predict_bytes(input in_t t);
    int   len;
    int   distance;
    int   idx;
    int   base;
    int   xb;
    int   sym;
    out_t o;
    if (t.command > CMD_FLUSH) begin
      n_ignored++;
      return;
    end
    acc   = 64'(pend_bits);
    acc_n = pend_cnt;
    case (t.command)
      CMD_LITERAL: begin
        n_literal++;
        if (t.literal < LIT_BREAK) put_msb(LIT_CODE_A + t.literal, 8);
        else put_msb(LIT_CODE_B + t.literal - LIT_BREAK, 9);
      end
      CMD_MATCH: begin
        n_match++;
        len      = t.match_length;
        distance = t.match_distance;
        if (len < LEN_SHORTEST || len > LEN_LONGEST || distance == 0 ||
            distance > DIST_LONGEST)
          n_clamped++;
        if (len < LEN_SHORTEST) len = LEN_SHORTEST;
        if (len > LEN_LONGEST) len = LEN_LONGEST;
        if (distance < 1) distance = 1;
        if (distance > DIST_LONGEST) distance = DIST_LONGEST;
        length_slot(len, idx, base, xb);
        sym = LEN_SYM_FIRST + idx;
        if (sym < LEN_SYM_SHORT) put_msb(sym - 256, 7);
        else put_msb(LEN_CODE_EIGHT + sym - LEN_SYM_SHORT, 8);
        put_lsb(len - base, xb);
        distance_slot(distance, idx, base, xb);
        put_msb(idx, 5);
        put_lsb(distance - base, xb);
      end
      CMD_HEADER: begin
        n_header++;
        put_msb(t.final_block ? HDR_FINAL : HDR_MORE, 3);
      end
      CMD_EOB: begin
        n_eob++;
        put_msb(EOB_CODE, 7);
      end
      default: begin
        // Flush: pad any partial byte with zeros at the top.
        n_flush++;
        if (acc_n > 0) acc_n = 8;
        else n_empty_fl++;
      end
    endcase
    while (acc_n >= 8) begin
      o.out_byte  = acc[7:0];
      o.last_byte = (acc_n < 16);
      expected_bytes.insert(expected_bytes.size(), o);
      acc   = acc >> 8;
      acc_n -= 8;
    end
    pend_bits = acc[6:0];
    pend_cnt  = acc_n;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: the predictor runs on every token transfer, the checker on every
  // byte transfer. A token cannot yield a byte at its own transfer edge, so the
  // two never race for the same expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && token_valid && token_ready) predict_bytes(token);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && stream_valid && stream_ready) begin
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte transfer: out_byte %02h last_byte %0b",
               stream_data.out_byte, stream_data.last_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (stream_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, stream_data.out_byte);
          errors++;
        end
        if (stream_data.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", want.last_byte,
                 stream_data.last_byte);
          errors++;
        end
      end
    end
  end

  // Back-pressure on the byte side; redrawn every cycle.
  always @(posedge clk) begin
    stream_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((token_valid && token_ready) || (stream_valid && stream_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes still expected",
               IDLE_LIMIT, expected_bytes.size());
      $display("deflate_fixed_huffman_token_encoder test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one token, optionally after an idle gap, and hold it until the transfer.
  // Valid is only lowered when a gap is inserted, so it never toggles within a step.
  task automatic send_token(input in_t t);
    if ($urandom_range(99) < tx_idle_pct) begin
      token_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    token_valid <= 1'b1;
    token       <= t;
    do @(posedge clk); while (!token_ready);
    if (t.command <= CMD_FLUSH) tokens_sent++;
  endtask

  // Fill every field at random; callers override what they care about.
  function automatic in_t random_fields();
    in_t t;
    t.command        = 3'($urandom_range(0, 7));
    t.literal        = 8'($urandom);
    t.match_length   = 9'($urandom);
    t.match_distance = 16'($urandom);
    t.final_block    = 1'($urandom);
    return t;
  endfunction

  task automatic send_match(input int len, input int distance);
    in_t t;
    t = random_fields();
    t.command        = CMD_MATCH;
    t.match_length   = 9'(len);
    t.match_distance = 16'(distance);
    send_token(t);
  endtask

  task automatic test_literals();
    int  lits [4] = '{0, 143, 144, 255};
    in_t t;
    foreach (lits[i]) begin
      t = random_fields();
      t.command = CMD_LITERAL;
      t.literal = 8'(lits[i]);
      send_token(t);
    end
  endtask

  // Both ends of each range, the clamps on either side, and the widest extra fields.
  task automatic test_matches();
    send_match(3, 1);
    send_match(258, 32768);
    send_match(0, 0);
    send_match(511, 65535);
    send_match(259, 32769);
    send_match(227, 24577);
    send_match(257, 5);
    send_match(11, 12288);
  endtask

  task automatic test_header_and_eob();
    in_t t;
    t = random_fields();
    t.command     = CMD_HEADER;
    t.final_block = 1'b1;
    send_token(t);
    t.final_block = 1'b0;
    send_token(t);
    t = random_fields();
    t.command = CMD_EOB;
    send_token(t);
  endtask

  // Leave a partial byte, flush it, flush again with nothing pending, then the
  // three unused commands.
  task automatic test_flush_and_unused();
    in_t t;
    t = random_fields();
    t.command = CMD_HEADER;
    send_token(t);
    t = random_fields();
    t.command = CMD_FLUSH;
    send_token(t);
    send_token(t);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      t = random_fields();
      t.command = 3'(c);
      send_token(t);
    end
  endtask

  // One deflate block: usually a header, a body of literals and matches with some
  // noise, usually an end of block, sometimes a flush.
  task automatic send_random_block();
    in_t t;
    int  body;
    int  r;
    body = $urandom_range(1, 14);
    if ($urandom_range(9) != 0) begin
      t = random_fields();
      t.command = CMD_HEADER;
      send_token(t);
    end
    for (int k = 0; k < body; k++) begin
      t = random_fields();
      r = $urandom_range(99);
      if (r < 10) begin
        // keep the fully random token: any command, any field
      end else if (r < 15) begin
        t.command = CMD_FLUSH;
      end else if (r < 55) begin
        t.command = CMD_LITERAL;
      end else begin
        t.command = CMD_MATCH;
        r = $urandom_range(99);
        if (r >= 20) t.match_length = 9'($urandom_range(LEN_SHORTEST, LEN_LONGEST));
        else if (r >= 12) t.match_length = 9'(LEN_LONGEST);
        r = $urandom_range(99);
        if (r >= 60) t.match_distance = 16'($urandom_range(1, 300));
        else if (r >= 20) t.match_distance = 16'($urandom_range(1, DIST_LONGEST));
        else if (r >= 12) t.match_distance = 16'(DIST_LONGEST - $urandom_range(0, 8191));
      end
      send_token(t);
    end
    if ($urandom_range(9) != 0) begin
      t = random_fields();
      t.command = CMD_EOB;
      send_token(t);
    end
    if ($urandom_range(2) == 0) begin
      t = random_fields();
      t.command = CMD_FLUSH;
      send_token(t);
    end
  endtask

  task automatic test_random_stream(input int n_tokens, input int tx_pct, input int rx_pct);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = tokens_sent;
    while (tokens_sent - start < n_tokens) send_random_block();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_literals();
    test_matches();
    test_header_and_eob();
    test_flush_and_unused();

    test_random_stream(140, 30, 68);
    test_random_stream(150, 68, 30);
    test_random_stream(150, 0, 0);

    // Drop valid, drain every expected byte, then allow for the pipeline tail.
    token_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("covered %0d tokens (%0d literal, %0d match with %0d clamped, %0d header, %0d eob)",
             tokens_sent, n_literal, n_match, n_clamped, n_header, n_eob);
    $display("and %0d flushes (%0d empty), %0d ignored commands, %0d bytes checked",
             n_flush, n_empty_fl, n_ignored, bytes_seen);
    if (errors == 0) begin
      $display("deflate_fixed_huffman_token_encoder test passed");
    end else begin
      $display("deflate_fixed_huffman_token_encoder test failed");
    end
    $finish;
  end

endmodule
